// File: design/mfw_pkg.sv
package mfw_pkg;

    localparam int NUM_WHEELS      = 4;
    localparam int SPEED_FRAC_BITS = 8;
    localparam int SPEED_W         = 26;
    localparam int ERR_W           = 27;
    localparam int ACC_W           = 17;
    localparam int ROT_W           = 28;
    localparam int DEN_W           = 48;
    localparam int NUM_W           = 56;
    localparam int QUO_W           = 25;
    localparam int STEP_W          = 5;
    localparam int CFG_ADDR_W      = 5;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [ERR_W-1:0] JUMP_LIMIT = ERR_W'(500 << SPEED_FRAC_BITS);
    localparam logic [QUO_W-1:0] SPEED_SAT = '1;

    typedef enum logic [1:0] {
        DIR_STOP    = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        REG_KP_GAIN    = 3'd0,
        REG_KI_GAIN    = 3'd1,
        REG_MAX_DUTY   = 3'd2,
        REG_MAX_RPM    = 3'd3,
        REG_GEOMETRY   = 3'd4,
        REG_MM_TO_RPM  = 3'd5,
        REG_PULSES     = 3'd6,
        REG_REV_MASK   = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        L_IDLE,
        L_MIX,
        L_TGT,
        L_MUL,
        L_CHK,
        L_DIV,
        L_SPD,
        L_PIMUL,
        L_PISUM,
        L_ACC
    } lane_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_START,
        T_RUN,
        T_OUT
    } top_state_t;

    typedef struct packed {
        logic                     start_vel;
        logic                     start_tick;
        logic signed [15:0]       vel_x;
        logic signed [15:0]       vel_y;
        logic signed [ROT_W-1:0]  rot;
        logic [DEN_W-1:0]         den;
        logic                     den_zero;
        logic [15:0]              kp_gain;
        logic [15:0]              ki_gain;
        logic [15:0]              max_duty;
        logic [15:0]              max_wheel_rpm;
        logic [15:0]              mm_to_rpm_factor;
    } lane_ctrl_t;

    typedef struct packed {
        logic        done;
        logic [15:0] duty;
        dir_t        dir;
    } lane_out_t;

endpackage

// File: design/mfw_lane.sv
module mfw_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  mfw_pkg::lane_ctrl_t ctrl,
    input  logic               x_neg,
    input  logic               r_neg,
    input  logic               reverse,
    input  logic [31:0]        count,
    output mfw_pkg::lane_out_t result
);

    localparam int ERR_W   = mfw_pkg::ERR_W;
    localparam int SPEED_W = mfw_pkg::SPEED_W;
    localparam int ACC_W   = mfw_pkg::ACC_W;
    localparam int STEP_W  = mfw_pkg::STEP_W;
    localparam int NUM_W   = mfw_pkg::NUM_W;

    mfw_pkg::lane_state_t state_reg, state_next;

    logic signed [mfw_pkg::SPEED_W-1:0] target_reg;
    logic signed [mfw_pkg::SPEED_W-1:0] meas_reg;
    logic signed [mfw_pkg::ERR_W-1:0]   lerr_reg;
    logic signed [mfw_pkg::ACC_W-1:0]   acc_reg;
    logic [31:0]                        lcount_reg;

    logic signed [45:0]                 prod_reg;
    logic                               dneg_reg;
    logic [31:0]                        dmag_reg;
    logic [mfw_pkg::NUM_W-1:0]          num_reg;
    logic [mfw_pkg::NUM_W-1:0]          rem_reg;
    logic [71:0]                        dsh_reg;
    logic [mfw_pkg::QUO_W-1:0]          quo_reg;
    logic [mfw_pkg::STEP_W-1:0]         step_reg;
    logic signed [44:0]                 pk_reg;
    logic signed [43:0]                 pi_reg;
    logic signed [30:0]                 inc_reg;

    logic signed [28:0] mix;
    logic signed [28:0] x_term;
    logic signed [28:0] r_term;
    logic [45:0]        prod_mag;
    logic [37:0]        prod_sh;
    logic [37:0]        rpm_lim;
    logic [37:0]        tgt_mag;
    logic [31:0]        cnt;
    logic [31:0]        dlt;
    logic [72:0]        den_top;
    logic [71:0]        rem_ext;
    logic signed [mfw_pkg::SPEED_W-1:0] v;
    logic signed [mfw_pkg::ERR_W-1:0]   vdiff;
    logic [mfw_pkg::ERR_W-1:0]          vdiff_mag;
    logic signed [mfw_pkg::ERR_W-1:0]   err;
    logic signed [27:0]                 derr;
    logic signed [45:0]                 inc;
    logic [45:0]                        inc_mag;
    logic [29:0]                        inc_sh;
    logic signed [31:0]                 acc_sum;
    logic signed [31:0]                 dlim;

    always_comb
    begin
        x_term   = 29'(ctrl.vel_x);
        r_term   = 29'(ctrl.rot);
        mix      = 29'(ctrl.vel_y) + (x_neg ? -x_term : x_term) + (r_neg ? -r_term : r_term);
        prod_mag = prod_reg[45] ? 46'(-prod_reg) : 46'(prod_reg);
        prod_sh  = prod_mag[45:8];
        rpm_lim  = 38'({ctrl.max_wheel_rpm, 8'd0});
        tgt_mag  = (prod_sh > rpm_lim) ? rpm_lim : prod_sh;
        cnt      = reverse ? 32'(-count) : count;
        dlt      = cnt - lcount_reg;
        den_top  = {ctrl.den, 25'd0};
        rem_ext  = 72'(rem_reg);
        v        = dneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        vdiff    = ERR_W'(v) - ERR_W'(meas_reg);
        vdiff_mag = vdiff[mfw_pkg::ERR_W-1] ? ERR_W'(-vdiff) : ERR_W'(vdiff);
        err      = ERR_W'(target_reg) - ERR_W'(meas_reg);
        derr     = 28'(err) - 28'(lerr_reg);
        inc      = 46'(pk_reg) + 46'(pi_reg);
        inc_mag  = inc[45] ? 46'(-inc) : 46'(inc);
        inc_sh   = inc_mag[45:16];
        acc_sum  = 32'(acc_reg) + 32'(inc_reg);
        dlim     = 32'({1'b0, ctrl.max_duty});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfw_pkg::L_IDLE:
            begin
                if (ctrl.start_vel)
                    state_next = mfw_pkg::L_MIX;
                else if (ctrl.start_tick)
                    state_next = mfw_pkg::L_MUL;
            end
            mfw_pkg::L_MIX:   state_next = mfw_pkg::L_TGT;
            mfw_pkg::L_TGT:   state_next = mfw_pkg::L_IDLE;
            mfw_pkg::L_MUL:   state_next = mfw_pkg::L_CHK;
            mfw_pkg::L_CHK:   state_next = mfw_pkg::L_DIV;
            mfw_pkg::L_DIV:
                if (step_reg == '0)
                    state_next = mfw_pkg::L_SPD;
            mfw_pkg::L_SPD:   state_next = mfw_pkg::L_PIMUL;
            mfw_pkg::L_PIMUL: state_next = mfw_pkg::L_PISUM;
            mfw_pkg::L_PISUM: state_next = mfw_pkg::L_ACC;
            mfw_pkg::L_ACC:   state_next = mfw_pkg::L_IDLE;
            default:          state_next = mfw_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mfw_pkg::L_IDLE;
            target_reg <= '0;
            meas_reg   <= '0;
            lerr_reg   <= '0;
            acc_reg    <= '0;
            lcount_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                mfw_pkg::L_IDLE:
                    if (!ctrl.start_vel && ctrl.start_tick)
                    begin
                        lcount_reg <= cnt;
                    end
                mfw_pkg::L_TGT:
                    target_reg <= prod_reg[45] ? -$signed(SPEED_W'(tgt_mag))
                                               : $signed(SPEED_W'(tgt_mag));
                mfw_pkg::L_SPD:
                    if (!ctrl.den_zero && vdiff_mag <= mfw_pkg::JUMP_LIMIT)
                        meas_reg <= v;
                mfw_pkg::L_PIMUL:
                    lerr_reg <= err;
                mfw_pkg::L_ACC:
                    if (acc_sum > dlim)
                        acc_reg <= ACC_W'(dlim);
                    else if (acc_sum < -dlim)
                        acc_reg <= ACC_W'(-dlim);
                    else
                        acc_reg <= ACC_W'(acc_sum);
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mfw_pkg::L_IDLE:
            begin
                dneg_reg <= dlt[31];
                dmag_reg <= dlt[31] ? 32'(-dlt) : dlt;
            end
            mfw_pkg::L_MIX:
                prod_reg <= 46'(mix) * 46'($signed({1'b0, ctrl.mm_to_rpm_factor}));
            mfw_pkg::L_MUL:
                num_reg <= {48'(dmag_reg * mfw_pkg::MS_PER_MINUTE), 8'd0};
            mfw_pkg::L_CHK:
            begin
                quo_reg  <= mfw_pkg::SPEED_SAT;
                rem_reg  <= num_reg;
                // saturate: a zero divisor or a quotient too large for the register shifts in ones for every step
                dsh_reg  <= (73'(num_reg) >= den_top) ? '0 : {ctrl.den, 24'd0};
                step_reg <= STEP_W'(mfw_pkg::QUO_W - 1);
            end
            mfw_pkg::L_DIV:
            begin
                if (rem_ext >= dsh_reg)
                begin
                    rem_reg <= NUM_W'(rem_ext - dsh_reg);
                    quo_reg <= {quo_reg[mfw_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[mfw_pkg::QUO_W-2:0], 1'b0};
                end
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - 1'b1;
            end
            mfw_pkg::L_PIMUL:
            begin
                pk_reg <= 45'(derr) * 45'($signed({1'b0, ctrl.kp_gain}));
                pi_reg <= 44'(err) * 44'($signed({1'b0, ctrl.ki_gain}));
            end
            mfw_pkg::L_PISUM:
                inc_reg <= inc[45] ? -$signed({1'b0, inc_sh}) : $signed({1'b0, inc_sh});
            default:
                ;
        endcase
    end

    always_comb
    begin
        result.done = (state_reg == mfw_pkg::L_ACC);
        result.duty = acc_reg[ACC_W-1] ? 16'(-acc_reg) : 16'(acc_reg);
        if (acc_reg > 0)
            result.dir = mfw_pkg::DIR_FORWARD;
        else if (acc_reg < 0)
            result.dir = mfw_pkg::DIR_REVERSE;
        else
            result.dir = mfw_pkg::DIR_STOP;
    end

endmodule

// File: design/mecanum_four_wheel_pi_speed_control.sv
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        s_tuser cmd, s_tdata velocity or tick
// m_*       out        m_tvalid / m_tready        m_tdata duty and direction per wheel
// apb       in/out     psel, penable, pready      eight 32-bit registers at 4*i
//
// A velocity transaction holds s_tready low while the sequencer steps through T_START
// and T_RUN. A tick holds it low until its result is loaded into the output register,
// which raises m_tvalid; a tick runs the 25-step restoring divider in each wheel lane.
// All four lanes run the same schedule in lockstep.
// rst_n clears every lane's speed, error, accumulator and last-count state and loads the
// register defaults. A result waiting on m_tready holds the block only when the
// next tick finishes; input is taken whenever the sequencer is idle.
module mecanum_four_wheel_pi_speed_control (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,  // vel_x, vel_y, rotation, now_ms, count_lf, _rf, _lr, _rr
    input  logic         s_tuser,  // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // duty_lf, dir_lf, duty_rf, dir_rf, duty_lr, dir_lr, ...rr
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    mfw_pkg::top_state_t state_reg, state_next;

    logic [15:0] kp_reg, ki_reg, max_duty_reg, max_rpm_reg, factor_reg, ppr_reg;
    logic [11:0] geom_reg;
    logic [3:0]  mask_reg;
    logic [31:0] last_time_reg;
    logic        cmd_reg;
    logic signed [15:0] x_reg, y_reg, rot_in_reg;
    logic [31:0] dt_reg;
    logic [31:0] count_reg [mfw_pkg::NUM_WHEELS];
    logic signed [mfw_pkg::ROT_W-1:0] rot_reg;
    logic [mfw_pkg::DEN_W-1:0] den_reg;
    logic        out_valid_reg;
    logic [71:0] out_data_reg;
    logic        vel_wait_reg;

    mfw_pkg::lane_ctrl_t ctrl;
    mfw_pkg::lane_out_t  lane_res [mfw_pkg::NUM_WHEELS];
    logic                accept;
    logic                cfg_wr;
    logic                out_free;
    logic                vel_done;
    mfw_pkg::reg_index_t cfg_idx;

    localparam logic [3:0] X_NEG = 4'b1001;
    localparam logic [3:0] R_NEG = 4'b0101;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == mfw_pkg::T_IDLE);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = mfw_pkg::reg_index_t'(paddr[4:2]);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign vel_done = !vel_wait_reg;

    always_comb
    begin
        unique case (cfg_idx)
            mfw_pkg::REG_KP_GAIN:   prdata = 32'(kp_reg);
            mfw_pkg::REG_KI_GAIN:   prdata = 32'(ki_reg);
            mfw_pkg::REG_MAX_DUTY:  prdata = 32'(max_duty_reg);
            mfw_pkg::REG_MAX_RPM:   prdata = 32'(max_rpm_reg);
            mfw_pkg::REG_GEOMETRY:  prdata = 32'(geom_reg);
            mfw_pkg::REG_MM_TO_RPM: prdata = 32'(factor_reg);
            mfw_pkg::REG_PULSES:    prdata = 32'(ppr_reg);
            mfw_pkg::REG_REV_MASK:  prdata = 32'(mask_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= 16'd256;
            ki_reg       <= 16'd256;
            max_duty_reg <= 16'd1000;
            max_rpm_reg  <= 16'd300;
            geom_reg     <= 12'd200;
            factor_reg   <= 16'd13107;
            ppr_reg      <= 16'd1320;
            mask_reg     <= 4'd5;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                mfw_pkg::REG_KP_GAIN:   kp_reg       <= pwdata[15:0];
                mfw_pkg::REG_KI_GAIN:   ki_reg       <= pwdata[15:0];
                mfw_pkg::REG_MAX_DUTY:  max_duty_reg <= pwdata[15:0];
                mfw_pkg::REG_MAX_RPM:   max_rpm_reg  <= pwdata[15:0];
                mfw_pkg::REG_GEOMETRY:  geom_reg     <= pwdata[11:0];
                mfw_pkg::REG_MM_TO_RPM: factor_reg   <= pwdata[15:0];
                mfw_pkg::REG_PULSES:    ppr_reg      <= pwdata[15:0];
                mfw_pkg::REG_REV_MASK:  mask_reg     <= pwdata[3:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfw_pkg::T_IDLE:
                if (accept)
                    state_next = mfw_pkg::T_START;
            mfw_pkg::T_START:
                state_next = mfw_pkg::T_RUN;
            mfw_pkg::T_RUN:
                if (!cmd_reg && vel_done)
                    state_next = mfw_pkg::T_IDLE;
                else if (cmd_reg && lane_res[0].done)
                    state_next = mfw_pkg::T_OUT;
            mfw_pkg::T_OUT:
                if (out_free)
                    state_next = mfw_pkg::T_IDLE;
            default:
                state_next = mfw_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfw_pkg::T_IDLE;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
            vel_wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && s_tuser)
                last_time_reg <= s_tdata[79:48];
            if (state_reg == mfw_pkg::T_START)
                vel_wait_reg <= 1'b1;
            else
                vel_wait_reg <= 1'b0;
            if (state_reg == mfw_pkg::T_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tuser;
            x_reg      <= s_tdata[15:0];
            y_reg      <= s_tdata[31:16];
            rot_in_reg <= s_tdata[47:32];
            dt_reg     <= s_tdata[79:48] - last_time_reg;
            count_reg[0] <= s_tdata[111:80];
            count_reg[1] <= s_tdata[143:112];
            count_reg[2] <= s_tdata[175:144];
            count_reg[3] <= s_tdata[207:176];
        end
        if (state_reg == mfw_pkg::T_START)
        begin
            rot_reg <= mfw_pkg::ROT_W'(rot_in_reg) * mfw_pkg::ROT_W'($signed({1'b0, geom_reg}));
            den_reg <= mfw_pkg::DEN_W'(dt_reg * ppr_reg);
        end
        if (state_reg == mfw_pkg::T_OUT && out_free)
        begin
            out_data_reg[17:16] <= lane_res[0].dir;
            out_data_reg[15:0]  <= lane_res[0].duty;
            out_data_reg[33:18] <= lane_res[1].duty;
            out_data_reg[35:34] <= lane_res[1].dir;
            out_data_reg[51:36] <= lane_res[2].duty;
            out_data_reg[53:52] <= lane_res[2].dir;
            out_data_reg[69:54] <= lane_res[3].duty;
            out_data_reg[71:70] <= lane_res[3].dir;
        end
    end

    always_comb
    begin
        ctrl.start_vel        = (state_reg == mfw_pkg::T_START) && !cmd_reg;
        ctrl.start_tick       = (state_reg == mfw_pkg::T_START) && cmd_reg;
        ctrl.vel_x            = x_reg;
        ctrl.vel_y            = y_reg;
        ctrl.rot              = rot_reg;
        ctrl.den              = den_reg;
        ctrl.den_zero         = (den_reg == '0);
        ctrl.kp_gain          = kp_reg;
        ctrl.ki_gain          = ki_reg;
        ctrl.max_duty         = max_duty_reg;
        ctrl.max_wheel_rpm    = max_rpm_reg;
        ctrl.mm_to_rpm_factor = factor_reg;
    end

    for (genvar w = 0; w < mfw_pkg::NUM_WHEELS; w++)
    begin : g_lane
        mfw_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .x_neg   (X_NEG[w]),
            .r_neg   (R_NEG[w]),
            .reverse (mask_reg[w]),
            .count   (count_reg[w]),
            .result  (lane_res[w])
        );
    end

endmodule
